### hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg - shared types and constants of the square matrix multiply engine
// Matrix size, field widths, command codes and the word types of both
// channels.
// ----------------------------------------------------------------------------
package smm_pkg;

   localparam int DIM    = 16;
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int DOT_W  = 40;
   localparam int K_W    = $clog2(DIM);
   localparam int ADDR_W = $clog2(DIM * DIM);

   typedef enum logic [1:0] {
      CMD_WR_A = 2'd0,
      CMD_WR_B = 2'd1,
      CMD_RD_C = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic [IDX_W-1:0]          row;
      logic [IDX_W-1:0]          col;
      logic signed [VAL_W-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [DOT_W-1:0]   dot_product;
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
   } rsp_type;

   // true when an index addresses a row or column of the matrix
   function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
      return (32'(idx) < 32'(DIM));
   endfunction

endpackage

### hdl/smm_req_if.sv
// ----------------------------------------------------------------------------
// smm_req_if - request channel of the matrix multiply engine
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface smm_req_if;
   import smm_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

### hdl/smm_rsp_if.sv
// ----------------------------------------------------------------------------
// smm_rsp_if - response channel of the matrix multiply engine
// Valid/ready handshake carrying one product element word.
// ----------------------------------------------------------------------------
interface smm_rsp_if;
   import smm_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

### hdl/square_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// square_matrix_multiply_top - matrix product engine, C = A x B
// Holds A and B in two synchronous memories and returns one element of C per
// read command as an exact 40-bit dot product.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                         handshake
//   -------   ---   --------------------------   -----------
//   req_ch    in    cmd, row, col, value         valid/ready
//   rsp_ch    out   dot_product, out_row, out_col valid/ready
//
// A write of A or B gives no word on rsp_ch.
// A read in range runs the single multiply-accumulate loop, which walks one
// element pair of row/column per cycle, behind the registered memory read
// and one product register.
// A read out of range returns zero.
// Reset is synchronous and clears control only; the memories stay undefined.
// A result waits in the output register while new writes are taken; a read
// finishing behind an unread result holds until rsp_ch drains.
// ----------------------------------------------------------------------------
module square_matrix_multiply_top (
   input  logic      clock,
   input  logic      reset,
   smm_req_if.sink   req_ch,
   smm_rsp_if.source rsp_ch
);
   import smm_pkg::*;

   localparam int AF_W = ADDR_W + IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // element memories, row-major
   logic signed [VAL_W-1:0] mem_a [DIM*DIM];
   logic signed [VAL_W-1:0] mem_b [DIM*DIM];

   // request capture
   logic [IDX_W-1:0] row_ff;
   logic [IDX_W-1:0] col_ff;

   // loop control
   logic [K_W-1:0] k_ff;
   logic           issue_ff;
   logic           rd_vld_ff;
   logic           rd_last_ff;
   logic           mul_vld_ff;
   logic           mul_last_ff;

   // datapath
   logic signed [VAL_W-1:0]  a_rd_ff;
   logic signed [VAL_W-1:0]  b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DOT_W-1:0]  acc_ff;
   logic signed [DOT_W-1:0]  acc_in;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic            req_fire;
   logic            req_in_range;
   logic            wr_en_a;
   logic            wr_en_b;
   logic [AF_W-1:0] wr_addr_full;
   logic [AF_W-1:0] a_addr_full;
   logic [AF_W-1:0] b_addr_full;
   logic            out_free;
   logic            k_last;
   logic            rsp_load;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_in_range = idx_ok(req_ch.data.row) && idx_ok(req_ch.data.col);

   assign wr_en_a = req_fire && req_in_range && (req_ch.data.cmd == CMD_WR_A);
   assign wr_en_b = req_fire && req_in_range && (req_ch.data.cmd == CMD_WR_B);

   // element addresses: A walks along row, B walks down column
   assign wr_addr_full = AF_W'(req_ch.data.row) * AF_W'(DIM) + AF_W'(req_ch.data.col);
   assign a_addr_full  = AF_W'(row_ff) * AF_W'(DIM) + AF_W'(k_ff);
   assign b_addr_full  = AF_W'(k_ff) * AF_W'(DIM) + AF_W'(col_ff);

   assign k_last   = (k_ff == K_W'(DIM - 1));
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = (state_ff == ST_FINISH) && out_free;
   assign acc_in   = acc_ff + DOT_W'(prod_ff);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // memory A: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en_a) begin
         mem_a[wr_addr_full[ADDR_W-1:0]] <= req_ch.data.value;
      end
      a_rd_ff <= mem_a[a_addr_full[ADDR_W-1:0]];
   end

   // memory B: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en_b) begin
         mem_b[wr_addr_full[ADDR_W-1:0]] <= req_ch.data.value;
      end
      b_rd_ff <= mem_b[b_addr_full[ADDR_W-1:0]];
   end

   // multiply stage: register each product before it is summed
   always_ff @(posedge clock) begin
      prod_ff <= a_rd_ff * b_rd_ff;
   end

   // sequencer, accumulator and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         mul_vld_ff   <= 1'b0;
         mul_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished sum, or drain the output word once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // advance the read pipeline every cycle
         rd_vld_ff   <= (state_ff == ST_RUN) && issue_ff;
         rd_last_ff  <= (state_ff == ST_RUN) && issue_ff && k_last;
         mul_vld_ff  <= rd_vld_ff;
         mul_last_ff <= rd_last_ff;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire && (req_ch.data.cmd == CMD_RD_C)) begin
                  row_ff <= req_ch.data.row;
                  col_ff <= req_ch.data.col;
                  acc_ff <= '0;
                  k_ff   <= '0;
                  if (req_in_range) begin
                     issue_ff <= 1'b1;
                     state_ff <= ST_RUN;
                  end else begin
                     state_ff <= ST_FINISH;
                  end
               end
            end
            ST_RUN: begin
               if (issue_ff) begin
                  k_ff <= k_ff + K_W'(1);
                  if (k_last) begin
                     issue_ff <= 1'b0;
                  end
               end
               if (mul_vld_ff) begin
                  acc_ff <= acc_in;
               end
               if (mul_last_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               // hold the sum until the output register is free
               if (rsp_load) begin
                  rsp_data_ff.dot_product <= acc_ff;
                  rsp_data_ff.out_row     <= row_ff;
                  rsp_data_ff.out_col     <= col_ff;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker - port-level assertions for the matrix multiply engine
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module smm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input smm_pkg::cmd_type      req_cmd,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input smm_pkg::rsp_type      rsp_data
);
   import smm_pkg::*;

   // response word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response word changed while stalled");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a write never creates a response word
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_WR_A || req_cmd == CMD_WR_B)
      && !rsp_valid |=> !rsp_valid)
      else $error("write produced a response");

   // a read occupies the engine for at least the following cycle
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_RD_C) |=> !req_ready)
      else $error("request taken during a read");

endmodule

bind square_matrix_multiply_top smm_checker u_smm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_cmd   (req_ch.data.cmd),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

### test/tb_square_matrix_multiply_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_matrix_multiply_top - self-checking bench of the matrix engine
// Loads A and B element by element, reads back elements of C = A x B and
// compares every product word with a local integer model. Reads only ever
// touch rows of A and columns of B that are fully written, and both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply_top;
   import smm_pkg::*;

   // code 3 has no enum member in the package; the engine must drop it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int WORD_TARGET  = 450;   // words that reach the matrices
   localparam int CALM_FROM    = 390;   // no idling from here on
   localparam int HOLD_AT      = 120;   // start of the long response stall
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_AT     = 260;   // sender waits for all products here
   localparam int TAIL_CYCLES  = 40;    // idle tail after the final drain
   localparam int DRAIN_LIMIT  = 4000;

   // -------------------------------------------------------------------------
   // Product tracker: keeps its own copy of A and B, works out C(row, col)
   // for every accepted read and holds the products still owed by the engine.
   // -------------------------------------------------------------------------
   class product_tracker;
      logic signed [VAL_W-1:0] elem_a [DIM*DIM];
      logic signed [VAL_W-1:0] elem_b [DIM*DIM];
      rsp_type                 owed [$];
      int                      fails;

      function new();
         foreach (elem_a[i]) elem_a[i] = '0;
         foreach (elem_b[i]) elem_b[i] = '0;
         fails = 0;
      endfunction

      function void note_request(req_type w);
         int      r;
         int      c;
         longint  acc;
         rsp_type want;
         r = int'(w.row);
         c = int'(w.col);
         case (w.cmd)
            CMD_WR_A: if (r < DIM && c < DIM) elem_a[r*DIM + c] = w.value;
            CMD_WR_B: if (r < DIM && c < DIM) elem_b[r*DIM + c] = w.value;
            CMD_RD_C: begin
               acc = 0;
               if (r < DIM && c < DIM) begin
                  for (int k = 0; k < DIM; k++)
                     acc += longint'(elem_a[r*DIM + k]) * longint'(elem_b[k*DIM + c]);
               end
               want.dot_product = acc[DOT_W-1:0];
               want.out_row     = w.row;
               want.out_col     = w.col;
               owed.push_back(want);
            end
            default: ;   // unused code: no state change, no product
         endcase
      endfunction

      function void check_product(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            $error("unexpected product word: row %0d col %0d dot_product %0d",
                   got.out_row, got.out_col, got.dot_product);
            fails++;
            return;
         end
         want = owed.pop_front();
         if (got.dot_product !== want.dot_product) begin
            $error("dot_product: expected %0d, actual %0d", want.dot_product,
                   got.dot_product);
            fails++;
         end
         if (got.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, got.out_row);
            fails++;
         end
         if (got.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, got.out_col);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   smm_req_if req_ch ();
   smm_rsp_if rsp_ch ();

   square_matrix_multiply_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   product_tracker products = new();

   // which elements have been written since reset; a read may only use
   // a row of A and a column of B that are written all the way through
   bit a_set [DIM][DIM];
   bit b_set [DIM][DIM];

   bit calm = 1'b0;            // set for the last stretch: no idling at all
   int long_hold_cycles = 0;   // raised once by the sender, counted down below
   int rsp_gap = 0;

   int words_sent = 0;
   int writes_sent = 0;
   int reads_sent = 0;
   int unused_sent = 0;
   int products_seen = 0;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Response side: random back-pressure bursts plus one long hold that the
   // sender asks for. The long hold is counted here, cycle by cycle.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (long_hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         long_hold_cycles--;
      end else if (rsp_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap--;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         // start a burst of low cycles, this one included; rsp_gap counts the rest
         rsp_ch.ready <= 1'b0;
         rsp_gap = $urandom_range(0, 6);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check every product word taken at this edge against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         products.check_product(rsp_ch.data);
         products_seen++;
      end
   end

   function automatic bit row_full(input int r);
      for (int k = 0; k < DIM; k++)
         if (!a_set[r][k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit col_full(input int c);
      for (int k = 0; k < DIM; k++)
         if (!b_set[k][c]) return 1'b0;
      return 1'b1;
   endfunction

   // Mostly random element values, with the two extremes showing up often.
   function automatic logic signed [VAL_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 7);
      if (roll == 0) return 16'sh8000;
      if (roll == 1) return 16'sh7fff;
      return VAL_W'($urandom);
   endfunction

   // -------------------------------------------------------------------------
   // Offer one word on req_ch and hold it until the engine takes it. Called
   // right after a rising edge; may first drop valid for a short idle burst.
   // -------------------------------------------------------------------------
   task automatic issue(input logic [1:0] code, input int r, input int c,
                        input logic signed [VAL_W-1:0] v);
      req_type w;
      w.cmd   = cmd_type'(code);
      w.row   = IDX_W'(r);
      w.col   = IDX_W'(c);
      w.value = v;
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // taken at this edge
      products.note_request(w);
      if (code == CMD_WR_A || code == CMD_WR_B) begin
         if (r < DIM && c < DIM) begin
            if (code == CMD_WR_A) a_set[r][c] = 1'b1;
            else b_set[r][c] = 1'b1;
         end
         writes_sent++;
         words_sent++;
      end else if (code == CMD_RD_C) begin
         reads_sent++;
         words_sent++;
      end else begin
         unused_sent++;
      end
   endtask

   // Hold the sender idle until the engine has returned everything it owes or limit runs out.
   // Valid always drops across a clock edge first, so it settles before the next word.
   task automatic wait_all_products(input int limit);
      int n;
      n = 0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      n++;
      while (products.owed.size() != 0 && n < limit) begin
         @(posedge clock);
         n++;
      end
   endtask

   // Time limit, far above the slowest legal run.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main stimulus.
   // -------------------------------------------------------------------------
   initial begin
      int choice;
      int r;
      int c;
      int n;
      bit held;
      bit drained;
      int rows_ok [$];
      int cols_ok [$];

      held    = 1'b0;
      drained = 1'b0;

      // drive everything known from time zero
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // Row 0 of A and column 0 of B at the most negative value: the largest
      // positive product, 16 * 2^30.
      for (int k = 0; k < DIM; k++) issue(CMD_WR_A, 0, k, 16'sh8000);
      for (int k = 0; k < DIM; k++) issue(CMD_WR_B, k, 0, 16'sh8000);
      issue(CMD_RD_C, 0, 0, 16'sh7fff);
      // unused code aimed at A(0,0): must change nothing
      issue(CMD_UNUSED, 0, 0, 16'sh0000);
      issue(CMD_RD_C, 0, 0, 16'sh0000);
      // mix of both extremes in one dot product
      issue(CMD_WR_A, 0, 0, 16'sh7fff);
      issue(CMD_RD_C, 0, 0, 16'sh8000);
      // far corner indices on both stores
      issue(CMD_WR_A, DIM-1, DIM-1, 16'sh7fff);
      issue(CMD_WR_B, DIM-1, DIM-1, 16'sh8000);

      // ---- random part: well-formed fills and reads with noise mixed in ----
      while (words_sent < WORD_TARGET) begin
         if (words_sent >= CALM_FROM) calm = 1'b1;

         // one long receiver hold while the sender keeps offering words
         if (!held && words_sent >= HOLD_AT) begin
            long_hold_cycles = HOLD_CYCLES;
            held = 1'b1;
         end

         // one full drain: sender pauses until every product is back
         if (!drained && words_sent >= DRAIN_AT) begin
            wait_all_products(DRAIN_LIMIT);
            drained = 1'b1;
         end

         choice = $urandom_range(0, 99);
         if (choice < 6) begin
            issue(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15), VAL_W'($urandom));
         end else if (choice < 13) begin
            r = $urandom_range(0, DIM-1);
            for (int k = 0; k < DIM; k++) issue(CMD_WR_A, r, k, pick_value());
         end else if (choice < 20) begin
            c = $urandom_range(0, DIM-1);
            for (int k = 0; k < DIM; k++) issue(CMD_WR_B, k, c, pick_value());
         end else if (choice < 40) begin
            issue($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A,
                  $urandom_range(0, 15), $urandom_range(0, 15), pick_value());
         end else begin
            // read only where the whole row and column are written
            rows_ok.delete();
            cols_ok.delete();
            for (int k = 0; k < DIM; k++) begin
               if (row_full(k)) rows_ok.push_back(k);
               if (col_full(k)) cols_ok.push_back(k);
            end
            r = rows_ok[$urandom_range(0, rows_ok.size()-1)];
            c = cols_ok[$urandom_range(0, cols_ok.size()-1)];
            issue(CMD_RD_C, r, c, VAL_W'($urandom));
         end
      end

      // ---- wind down: drop valid, collect what is owed, then a short tail ----
      wait_all_products(DRAIN_LIMIT);
      if (products.owed.size() != 0) begin
         $error("%0d product words never arrived", products.owed.size());
         products.fails++;
      end
      n = 0;
      while (n < TAIL_CYCLES) begin
         @(posedge clock);
         n++;
      end

      $display("Run covered %0d element writes, %0d product reads (%0d returned) and %0d",
               writes_sent, reads_sent, products_seen, unused_sent);
      $display("unused-code words, with one %0d-cycle response hold and one full drain.",
               HOLD_CYCLES);
      if (products.fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
